@@ hdl/srtn_pkg.sv @@
// Shared types for the shortest-remaining-time-next scheduler.
package srtn_pkg;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_ROTATE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     mark;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAKE,
    ST_REPLY
  } sched_state_t;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

endpackage

@@ hdl/srtn_if.sv @@
// Handshake channel interfaces for scheduler commands and results.
interface srtn_in_if #(
  parameter int ID_WIDTH   = 8,
  parameter int TIME_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [ID_WIDTH-1:0]   proc_id;
  logic [TIME_WIDTH-1:0] time_needed;

  modport source (output valid, command, proc_id, time_needed, input ready);
  modport sink   (input valid, command, proc_id, time_needed, output ready);
endinterface

interface srtn_out_if #(
  parameter int ID_WIDTH   = 8,
  parameter int TIME_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic                  running_valid;
  logic [ID_WIDTH-1:0]   running_id;
  logic [TIME_WIDTH-1:0] running_left;
  logic                  finished;
  logic [ID_WIDTH-1:0]   finished_id;
  logic                  preempted;
  logic                  dropped;

  modport source (output valid, running_valid, running_id, running_left, finished,
                  finished_id, preempted, dropped, input ready);
  modport sink   (input valid, running_valid, running_id, running_left, finished,
                  finished_id, preempted, dropped, output ready);
endinterface

@@ hdl/srtn_cell.sv @@
// One ready-queue slot: holds an id, a remaining time and a min-search mark.
module srtn_cell #(
  parameter int ID_WIDTH   = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srtn_pkg::cell_ctrl_t    ctrl,
  input  logic                    is_tail,
  input  logic                    push_sel,
  input  logic [ID_WIDTH-1:0]     push_id,
  input  logic [TIME_WIDTH-1:0]   push_time,
  input  logic [ID_WIDTH-1:0]     head_id,
  input  logic [TIME_WIDTH-1:0]   head_time,
  input  logic                    head_flag,
  input  logic [ID_WIDTH-1:0]     nxt_id,
  input  logic [TIME_WIDTH-1:0]   nxt_time,
  input  logic                    nxt_flag,
  output logic [ID_WIDTH-1:0]     id,
  output logic [TIME_WIDTH-1:0]   tm,
  output logic                    flag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else begin
      unique case (ctrl.op)
        srtn_pkg::OP_HOLD: begin
        end
        srtn_pkg::OP_PUSH: begin
          if (push_sel) begin
            id   <= push_id;
            tm   <= push_time;
            flag <= 1'b0;
          end
        end
        srtn_pkg::OP_ROTATE: begin
          // head wraps to the tail; a new best clears every older mark
          if (is_tail) begin
            id   <= head_id;
            tm   <= head_time;
            flag <= head_flag | ctrl.mark;
          end else begin
            id   <= nxt_id;
            tm   <= nxt_time;
            flag <= nxt_flag & ~ctrl.mark;
          end
        end
        srtn_pkg::OP_SHIFT: begin
          id   <= nxt_id;
          tm   <= nxt_time;
          flag <= nxt_flag;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/srtn_chain.sv @@
// Ready queue as a row of cells, oldest entry at the head (cell 0).
module srtn_chain #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8,
  parameter int TIME_WIDTH  = 16,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srtn_pkg::cell_ctrl_t  ctrl,
  input  logic [CW-1:0]         count,
  input  logic [ID_WIDTH-1:0]   push_id,
  input  logic [TIME_WIDTH-1:0] push_time,
  output logic [ID_WIDTH-1:0]   head_id,
  output logic [TIME_WIDTH-1:0] head_time,
  output logic                  head_flag
);

  logic [ID_WIDTH-1:0]   ids   [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] times [QUEUE_DEPTH];
  logic                  flags [QUEUE_DEPTH];

  assign head_id   = ids[0];
  assign head_time = times[0];
  assign head_flag = flags[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0]   n_id;
    logic [TIME_WIDTH-1:0] n_time;
    logic                  n_flag;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_id   = ids[i];
      assign n_time = times[i];
      assign n_flag = flags[i];
    end else begin : g_mid
      assign n_id   = ids[i+1];
      assign n_time = times[i+1];
      assign n_flag = flags[i+1];
    end

    srtn_cell #(
      .ID_WIDTH   (ID_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .is_tail   (count == CW'(i + 1)),
      .push_sel  (count == CW'(i)),
      .push_id   (push_id),
      .push_time (push_time),
      .head_id   (ids[0]),
      .head_time (times[0]),
      .head_flag (flags[0]),
      .nxt_id    (n_id),
      .nxt_time  (n_time),
      .nxt_flag  (n_flag),
      .id        (ids[i]),
      .tm        (times[i]),
      .flag      (flags[i])
    );
  end

endmodule

@@ hdl/srtn_process_scheduler_top.sv @@
// Shortest-remaining-time-next scheduler: control FSM, running process and result register.
//
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------------------
//  in_ch    | sink   | command, proc_id, time_needed
//  out_ch   | source | running_valid/id/left, finished, finished_id, preempted, dropped
//
// An arrival, or a tick while a process runs, goes from idle straight to the reply state.
// A tick with nothing running and entries queued first rotates the queue once through the
// head cell to mark the oldest minimum, then once more to pull that entry out and restore
// age order.
// Reset is synchronous and empties the queue; queue payload is not cleared.
// One result register; a new command is taken while an earlier result waits.
module srtn_process_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic              clk,
  input  logic              rst,
  srtn_in_if.sink           in_ch,
  srtn_out_if.source        out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  srtn_pkg::sched_state_t state, state_next;
  srtn_pkg::cell_ctrl_t   ctrl;

  logic [CW-1:0]         count;
  logic [CW-1:0]         cnt;
  logic                  run_valid;
  logic [ID_WIDTH-1:0]   run_id;
  logic [TIME_WIDTH-1:0] run_time;
  logic [TIME_WIDTH-1:0] best_time;
  logic                  fin;
  logic [ID_WIDTH-1:0]   fin_id;
  logic                  pre;
  logic                  drop;

  logic [ID_WIDTH-1:0]   push_id;
  logic [TIME_WIDTH-1:0] push_time;
  logic [ID_WIDTH-1:0]   head_id;
  logic [TIME_WIDTH-1:0] head_time;
  logic                  head_flag;

  logic take_in;
  logic is_arrive;
  logic preempt;
  logic full;
  logic new_best;
  logic load_out;

  assign take_in   = in_ch.valid && in_ch.ready;
  assign is_arrive = (in_ch.command == srtn_pkg::CMD_ARRIVE);
  assign preempt   = run_valid && (in_ch.time_needed < run_time);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign new_best  = (cnt == count) || (head_time < best_time);
  assign push_id   = preempt ? run_id   : in_ch.proc_id;
  assign push_time = preempt ? run_time : in_ch.time_needed;
  assign in_ch.ready = (state == srtn_pkg::ST_IDLE) && !rst;

  srtn_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .count     (count),
    .push_id   (push_id),
    .push_time (push_time),
    .head_id   (head_id),
    .head_time (head_time),
    .head_flag (head_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl.op    = srtn_pkg::OP_HOLD;
    ctrl.mark  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      srtn_pkg::ST_IDLE: begin
        if (take_in) begin
          if (is_arrive) begin
            if (!full) begin
              ctrl.op = srtn_pkg::OP_PUSH;
            end
            state_next = srtn_pkg::ST_REPLY;
          end else if (run_valid || count == '0) begin
            state_next = srtn_pkg::ST_REPLY;
          end else begin
            state_next = srtn_pkg::ST_SCAN;
          end
        end
      end
      srtn_pkg::ST_SCAN: begin
        ctrl.op   = srtn_pkg::OP_ROTATE;
        ctrl.mark = new_best;
        if (cnt == CW'(1)) begin
          state_next = srtn_pkg::ST_TAKE;
        end
      end
      srtn_pkg::ST_TAKE: begin
        ctrl.op = head_flag ? srtn_pkg::OP_SHIFT : srtn_pkg::OP_ROTATE;
        if (cnt == CW'(1)) begin
          state_next = srtn_pkg::ST_REPLY;
        end
      end
      srtn_pkg::ST_REPLY: begin
        if (!out_ch.valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = srtn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srtn_pkg::ST_IDLE;
      end
    endcase
  end

  // run state, queue fill and per-command flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cnt       <= '0;
      run_valid <= 1'b0;
      run_id    <= '0;
      run_time  <= '0;
      fin       <= 1'b0;
      fin_id    <= '0;
      pre       <= 1'b0;
      drop      <= 1'b0;
    end else begin
      unique case (state)
        srtn_pkg::ST_IDLE: begin
          if (take_in) begin
            fin    <= 1'b0;
            fin_id <= '0;
            pre    <= 1'b0;
            drop   <= 1'b0;
            cnt    <= count;
            if (is_arrive) begin
              if (full) begin
                drop <= 1'b1;
              end else begin
                count <= count + CW'(1);
              end
              if (preempt) begin
                pre      <= 1'b1;
                run_id   <= in_ch.proc_id;
                run_time <= in_ch.time_needed;
              end
            end else if (run_valid) begin
              if (run_time <= TIME_WIDTH'(1)) begin
                fin       <= 1'b1;
                fin_id    <= run_id;
                run_valid <= 1'b0;
                run_id    <= '0;
                run_time  <= '0;
              end else begin
                run_time <= run_time - TIME_WIDTH'(1);
              end
            end
          end
        end
        srtn_pkg::ST_SCAN: begin
          if (new_best) begin
            best_time <= head_time;
          end
          cnt <= (cnt == CW'(1)) ? count : cnt - CW'(1);
        end
        srtn_pkg::ST_TAKE: begin
          cnt <= cnt - CW'(1);
          if (head_flag) begin
            count <= count - CW'(1);
            if (head_time <= TIME_WIDTH'(1)) begin
              fin    <= 1'b1;
              fin_id <= head_id;
            end else begin
              run_valid <= 1'b1;
              run_id    <= head_id;
              run_time  <= head_time - TIME_WIDTH'(1);
            end
          end
        end
        srtn_pkg::ST_REPLY: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.running_valid <= run_valid;
      out_ch.running_id    <= run_valid ? run_id : '0;
      out_ch.running_left  <= run_valid ? run_time : '0;
      out_ch.finished      <= fin;
      out_ch.finished_id   <= fin_id;
      out_ch.preempted     <= pre;
      out_ch.dropped       <= drop;
    end
  end

endmodule
